FILE: hdl/chacha20_stream_xor_core_defines.svh
// assertion macros for the chacha20 stream xor core checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CHACHA20_STREAM_XOR_CORE_DEFINES_SVH
`define CHACHA20_STREAM_XOR_CORE_DEFINES_SVH

// consequent must hold on the same edge
`define CCSX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccsx check failed: same-cycle implication");

// consequent must hold on the following edge
`define CCSX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccsx check failed: next-cycle implication");

`endif

FILE: hdl/ccsx_pkg.sv
// shared types, constants and helpers for the chacha20 stream xor core
// no dependencies
package ccsx_pkg;

  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned NUM_ROUNDS = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  // sequencer limits
  localparam logic [2:0] LOAD_LAST    = 3'd3;
  localparam logic [2:0] FIN_LAST     = 3'd4;
  localparam logic [2:0] STEP_LAST    = 3'd7;
  localparam logic [2:0] ISSUE_STEPS  = 3'(NUM_LANES);
  localparam logic [4:0] RND_LAST     = 5'(NUM_ROUNDS - 1);

  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_INIT_CTR = 3'd6
  } cfg_reg_t;

  typedef logic [31:0] word_t;
  typedef logic [NUM_LANES-1:0][31:0] quad_t;
  typedef logic [NUM_LANES-1:0][1:0] lane_addr_t;

  typedef struct packed {
    logic       en;
    lane_addr_t addr;
  } st_rd_t;

  typedef struct packed {
    logic       we;
    lane_addr_t addr;
    quad_t      data;
  } st_wr_t;

  typedef struct packed {
    logic       vld;
    lane_addr_t addr;
  } qr_tag_t;

  typedef struct packed {
    logic       we;
    logic [1:0] entry;
    quad_t      data;
  } ks_wr_t;

  typedef struct packed {
    logic       en;
    logic [5:0] pos;
  } ks_rd_t;

  function automatic word_t rotl32(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

FILE: hdl/chacha20_stream_xor_core.sv
// chacha20 stream xor core: one byte per transfer, xored with the keystream
// byte in a block: keystream read at accept, result registered once output is free
// first byte of a block: load, 20 rounds, finalize, ks read, then the xor step
// the round time is set by the quarter-round pipeline draining into the state banks
// synchronous active-low reset clears control, counter to one, registers to defaults
module chacha20_stream_xor_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_in,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_data_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccsx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccsx_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ccsx_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_FINAL = 6'b001000,
    ST_KS_RD = 6'b010000,
    ST_XOR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_lo_r;
  word_t            nonce_hi_r;
  word_t            init_ctr_r;

  logic [5:0] pos_r;
  logic       start_r;
  word_t      ctr_r;
  logic [5:0] cur_pos_r;
  logic [7:0] data_r;
  logic [2:0] cnt_r;
  logic [4:0] rnd_r;
  logic [2:0] step_r;
  qr_tag_t    iss_r, iss_nxt;
  logic       fin_vld_r;
  logic [1:0] fin_entry_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic             in_acc;
  logic             out_free;
  logic [5:0]       pos_eff;
  logic             need_blk;
  logic             issuing;
  lane_addr_t       qr_addr;
  logic [15:0][31:0] init_w;

  st_rd_t  st_rd;
  st_wr_t  st_wr, qr_wr;
  quad_t   st_rdata;
  ks_wr_t  ks_wr;
  ks_rd_t  ks_rd;
  logic [7:0] ks_byte;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      init_ctr_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY0:     key_r[0]   <= cfg_data;
        REG_KEY1:     key_r[1]   <= cfg_data;
        REG_KEY2:     key_r[2]   <= cfg_data;
        REG_KEY3:     key_r[3]   <= cfg_data;
        REG_NONCE_LO: nonce_lo_r <= cfg_data;
        REG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
        REG_INIT_CTR: init_ctr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // initial block matrix
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]         = SIGMA[i];
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = ctr_r;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign pos_eff  = start_r ? 6'd0 : pos_r;
  assign need_blk = (pos_eff == 6'd0);
  assign issuing  = (state_r == ST_ROUND) && (step_r < ISSUE_STEPS);

  // column rounds use one address in every bank, diagonal rounds skew by bank
  always_comb begin
    for (int r = 0; r < NUM_LANES; r++) begin
      qr_addr[r] = rnd_r[0] ? (step_r[1:0] + 2'(r)) : step_r[1:0];
    end
  end

  always_comb begin
    iss_nxt.vld  = issuing;
    iss_nxt.addr = qr_addr;
  end

  always_comb begin
    st_rd.en = issuing || ((state_r == ST_FINAL) && (cnt_r < FIN_LAST));
    for (int r = 0; r < NUM_LANES; r++) begin
      st_rd.addr[r] = (state_r == ST_ROUND) ? qr_addr[r] : cnt_r[1:0];
    end
  end

  always_comb begin
    if (state_r == ST_LOAD) begin
      st_wr.we = 1'b1;
      for (int r = 0; r < NUM_LANES; r++) begin
        st_wr.addr[r] = cnt_r[1:0];
        st_wr.data[r] = init_w[{2'(r), cnt_r[1:0]}];
      end
    end else begin
      st_wr = qr_wr;
    end
  end

  // finalize: working word plus initial word into the keystream entry
  always_comb begin
    ks_wr.we    = fin_vld_r;
    ks_wr.entry = fin_entry_r;
    for (int r = 0; r < NUM_LANES; r++) begin
      ks_wr.data[r] = st_rdata[r] + init_w[{2'(r), fin_entry_r}];
    end
  end

  assign ks_rd.en  = (in_acc && !need_blk) || (state_r == ST_KS_RD);
  assign ks_rd.pos = (state_r == ST_KS_RD) ? cur_pos_r : pos_eff;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = need_blk ? ST_LOAD : ST_XOR;
      ST_LOAD:  if (cnt_r == LOAD_LAST) state_nxt = ST_ROUND;
      ST_ROUND: if (step_r == STEP_LAST && rnd_r == RND_LAST) state_nxt = ST_FINAL;
      ST_FINAL: if (cnt_r == FIN_LAST) state_nxt = ST_KS_RD;
      ST_KS_RD: state_nxt = ST_XOR;
      ST_XOR:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      start_r     <= 1'b1;
      ctr_r       <= 32'd1;
      cnt_r       <= '0;
      rnd_r       <= '0;
      step_r      <= '0;
      iss_r       <= '0;
      fin_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_r     <= iss_nxt;
      fin_vld_r <= (state_r == ST_FINAL) && (cnt_r < FIN_LAST);

      if (in_acc) begin
        start_r <= in_last_byte;
        pos_r   <= in_last_byte ? 6'd0 : pos_eff + 6'd1;
        if (start_r) begin
          ctr_r <= init_ctr_r;
        end
      end

      case (state_r)
        ST_IDLE: cnt_r <= '0;
        ST_LOAD: begin
          cnt_r  <= (cnt_r == LOAD_LAST) ? 3'd0 : cnt_r + 3'd1;
          rnd_r  <= '0;
          step_r <= '0;
        end
        ST_ROUND: begin
          cnt_r  <= '0;
          step_r <= step_r + 3'd1;
          if (step_r == STEP_LAST) begin
            rnd_r <= rnd_r + 5'd1;
          end
        end
        ST_FINAL: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == FIN_LAST) begin
            ctr_r <= ctr_r + 32'd1;
          end
        end
        default: ;
      endcase

      if (state_r == ST_XOR && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r    <= in_data_in;
      cur_pos_r <= pos_eff;
    end
    fin_entry_r <= cnt_r[1:0];
    if (state_r == ST_XOR && out_free) begin
      out_data_r <= data_r ^ ks_byte;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  ccsx_state_mem u_state_mem (
    .clk   (clk),
    .rd    (st_rd),
    .wr    (st_wr),
    .rdata (st_rdata)
  );

  ccsx_qr_pipe u_qr_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (iss_r),
    .din    (st_rdata),
    .wr     (qr_wr)
  );

  ccsx_ks_mem u_ks_mem (
    .clk     (clk),
    .wr      (ks_wr),
    .rd      (ks_rd),
    .ks_byte (ks_byte)
  );

endmodule

FILE: hdl/ccsx_state_mem.sv
// banked working-state memory, one bank per matrix row, one read and one write
// per bank per cycle, registered read data; depends on ccsx_pkg
module ccsx_state_mem (
  input  logic             clk,
  input  ccsx_pkg::st_rd_t rd,
  input  ccsx_pkg::st_wr_t wr,
  output ccsx_pkg::quad_t  rdata
);
  import ccsx_pkg::*;

  quad_t rdata_r;

  for (genvar r = 0; r < NUM_LANES; r++) begin : g_bank
    word_t bank_mem [NUM_LANES];

    always_ff @(posedge clk) begin
      if (wr.we) begin
        bank_mem[wr.addr[r]] <= wr.data[r];
      end
      if (rd.en) begin
        rdata_r[r] <= bank_mem[rd.addr[r]];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ccsx_qr_pipe.sv
// quarter-round unit, one add per stage, write-back addresses travel along
// lanes are a, b, c, d in order; depends on ccsx_pkg
module ccsx_qr_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  ccsx_pkg::qr_tag_t tag_in,
  input  ccsx_pkg::quad_t   din,
  output ccsx_pkg::st_wr_t  wr
);
  import ccsx_pkg::*;

  qr_tag_t tag1_r, tag2_r, tag3_r;
  quad_t   q1_r, q2_r, q3_r;
  quad_t   q1_nxt, q2_nxt, q3_nxt, q4;

  always_comb begin
    q1_nxt    = din;
    q1_nxt[0] = din[0] + din[1];
    q1_nxt[3] = rotl32(din[3] ^ q1_nxt[0], ROT_A);

    q2_nxt    = q1_r;
    q2_nxt[2] = q1_r[2] + q1_r[3];
    q2_nxt[1] = rotl32(q1_r[1] ^ q2_nxt[2], ROT_B);

    q3_nxt    = q2_r;
    q3_nxt[0] = q2_r[0] + q2_r[1];
    q3_nxt[3] = rotl32(q2_r[3] ^ q3_nxt[0], ROT_C);

    q4        = q3_r;
    q4[2]     = q3_r[2] + q3_r[3];
    q4[1]     = rotl32(q3_r[1] ^ q4[2], ROT_D);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    q1_r <= q1_nxt;
    q2_r <= q2_nxt;
    q3_r <= q3_nxt;
  end

  assign wr.we   = tag3_r.vld;
  assign wr.addr = tag3_r.addr;
  assign wr.data = q4;

endmodule

FILE: hdl/ccsx_ks_mem.sv
// keystream block memory, four 128-bit entries, registered read with byte pick
// entry k holds words k, k+4, k+8, k+12; depends on ccsx_pkg
module ccsx_ks_mem (
  input  logic             clk,
  input  ccsx_pkg::ks_wr_t wr,
  input  ccsx_pkg::ks_rd_t rd,
  output logic [7:0]       ks_byte
);
  import ccsx_pkg::*;

  quad_t      ks_mem [NUM_LANES];
  quad_t      line_r;
  logic [1:0] lane_r;
  logic [1:0] sel_r;
  word_t      word_sel;
  word_t      word_shift;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      ks_mem[wr.entry] <= wr.data;
    end
    if (rd.en) begin
      line_r <= ks_mem[rd.pos[3:2]];
      lane_r <= rd.pos[5:4];
      sel_r  <= rd.pos[1:0];
    end
  end

  assign word_sel   = line_r[lane_r];
  assign word_shift = word_sel >> {sel_r, 3'b000};
  assign ks_byte    = word_shift[7:0];

endmodule

FILE: hdl/ccsx_checker.sv
// port-level checks for the chacha20 stream xor core, bound to the top level
// depends on chacha20_stream_xor_core_defines.svh
`include "chacha20_stream_xor_core_defines.svh"

module ccsx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_out
);

  // one byte in flight: an input transfer closes the input side
  `CCSX_ASSERT_NEXT(a_in_one_at_a_time, in_valid && !in_stall, in_stall)

  // a result only shows up while an item is being worked on
  `CCSX_ASSERT_SAME(a_out_after_work, $rose(out_valid), $past(in_stall))

  `CCSX_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid)

  `CCSX_ASSERT_NEXT(a_out_data_holds, out_valid && out_stall, $stable(out_data_out))

endmodule

bind chacha20_stream_xor_core ccsx_checker u_ccsx_checker (.*);
